/* rtl/pso_pkg.sv */
// ----------------------------------------------------------------------------
// PSO velocity update package
// Widths, fixed-point constants and the side-data type shared by the
// channel interfaces and the velocity update pipeline.
// ----------------------------------------------------------------------------
package pso_pkg;

    // Field widths.
    localparam int POS_W  = 32;
    localparam int RATE_W = 17;
    localparam int COEF_W = 18;

    // Internal widths.
    localparam int RHO_W   = 19;
    localparam int SQN_W   = 38;
    localparam int ROOT_W  = 19;
    localparam int SQR_W   = 22;
    localparam int DEN_W   = 20;
    localparam int DIVR_W  = 36;
    localparam int Q_W     = 16;
    localparam int T_W     = 39;
    localparam int CHI_W   = 18;
    localparam int U_W     = 41;

    // Iteration counts of the square root and the divider.
    localparam int SQ_STEPS = 19;
    localparam int DV_STEPS = 16;

    // Fixed-point constants in Q16.16; DIV_NUM is 2.0 scaled by 2^32.
    localparam logic [RATE_W-1:0]       INERTIA_RESET = 17'd6554;
    localparam logic [RHO_W-1:0]        FX_FOUR       = 19'd262144;
    localparam logic [DEN_W-1:0]        FX_TWO        = 20'd131072;
    localparam logic signed [CHI_W-1:0] FX_ONE        = 18'sd65536;
    localparam logic [DIVR_W-1:0]       DIV_NUM       = 36'h2_0000_0000;

    // Data that travels alongside the constriction factor computation.
    typedef struct packed {
        logic signed [T_W-1:0]   t;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] vmax;
        logic signed [POS_W-1:0] vmin;
        logic                    last;
        logic                    big;
        logic [RHO_W-1:0]        rho;
    } side_t;

endpackage

/* rtl/pso_item_if.sv */
// ----------------------------------------------------------------------------
// PSO item channel
// Valid/ready channel that carries one decision dimension of one particle.
// ----------------------------------------------------------------------------
interface pso_item_if
    import pso_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  position;
    logic signed [POS_W-1:0]  velocity_in;
    logic signed [POS_W-1:0]  personal_best;
    logic signed [POS_W-1:0]  leader_pos;
    logic [RATE_W-1:0]        rand_cognitive;
    logic [RATE_W-1:0]        rand_social;
    logic [COEF_W-1:0]        cognitive_coeff;
    logic [COEF_W-1:0]        social_coeff;
    logic signed [POS_W-1:0]  vel_max;
    logic signed [POS_W-1:0]  vel_min;
    logic                     last_dim;

    modport source (
        output valid, position, velocity_in, personal_best, leader_pos,
               rand_cognitive, rand_social, cognitive_coeff, social_coeff,
               vel_max, vel_min, last_dim,
        input  ready
    );
    modport sink (
        input  valid, position, velocity_in, personal_best, leader_pos,
               rand_cognitive, rand_social, cognitive_coeff, social_coeff,
               vel_max, vel_min, last_dim,
        output ready
    );
endinterface

/* rtl/pso_res_if.sv */
// ----------------------------------------------------------------------------
// PSO result channel
// Valid/ready channel that carries the updated velocity and position.
// ----------------------------------------------------------------------------
interface pso_res_if
    import pso_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] new_velocity;
    logic signed [POS_W-1:0] new_position;
    logic                    last_dim_out;

    modport source (
        output valid, new_velocity, new_position, last_dim_out,
        input  ready
    );
    modport sink (
        input  valid, new_velocity, new_position, last_dim_out,
        output ready
    );
endinterface

/* rtl/pso_velocity_update.sv */
// ----------------------------------------------------------------------------
// PSO velocity update
// Constricted, clamped velocity and saturated position for one dimension.
// ----------------------------------------------------------------------------
// Usage:
// Beats enter on the item channel and leave on the result channel, one
// result beat per item beat, in order. The inertia weight is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle,
// as the block itself does not enforce this. A result passes 4 front stages,
// 19 square root steps, 16 divide steps, the constriction multiply and the
// clamp stage before it becomes valid. Throughput: one beat per cycle
// unless a receiver stall fills the pipeline; every stage holds one beat and
// the square root and divider each resolve one result bit per stage.
// Reset clears every valid bit and sets the inertia weight to 6554.
// When the receiver stalls, the output beat holds; earlier stages keep
// filling empty slots, and ready drops only once the pipeline is full.
// ----------------------------------------------------------------------------
module pso_velocity_update
    import pso_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [RATE_W-1:0] cfg_wdata,
    pso_item_if.sink          item,
    pso_res_if.source         res
);

    localparam int ST_SQ0 = 4;
    localparam int ST_SQL = ST_SQ0 + SQ_STEPS - 1;
    localparam int ST_DV0 = ST_SQL + 1;
    localparam int ST_DVL = ST_DV0 + DV_STEPS - 1;
    localparam int ST_MUL = ST_DVL + 1;
    localparam int ST_OUT = ST_MUL + 1;

    logic [RATE_W-1:0] inertia_reg;
    logic              vl_reg [0:ST_OUT];
    logic              stg_en [0:ST_OUT];

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inertia_reg <= INERTIA_RESET;
        end
        else if (cfg_we)
        begin
            inertia_reg <= cfg_wdata;
        end
    end

    // A stage may load when it is empty or when the stage after it loads.
    always_comb
    begin
        stg_en[ST_OUT] = !vl_reg[ST_OUT] || res.ready;
        for (int k = ST_OUT - 1; k >= 0; k--)
        begin
            stg_en[k] = !vl_reg[k] || stg_en[k + 1];
        end
    end

    assign item.ready = stg_en[0];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ST_OUT; k++)
            begin
                vl_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (stg_en[0])
            begin
                vl_reg[0] <= item.valid;
            end
            for (int k = 1; k <= ST_OUT; k++)
            begin
                if (stg_en[k])
                begin
                    vl_reg[k] <= vl_reg[k - 1];
                end
            end
        end
    end

    // Stage 0: input capture.
    logic signed [POS_W-1:0] in_x_reg, in_v_reg, in_pb_reg, in_gb_reg;
    logic signed [POS_W-1:0] in_vmax_reg, in_vmin_reg;
    logic [RATE_W-1:0]       in_r1_reg, in_r2_reg;
    logic [COEF_W-1:0]       in_c1_reg, in_c2_reg;
    logic                    in_last_reg;

    always_ff @(posedge clk)
    begin
        if (stg_en[0])
        begin
            in_x_reg    <= item.position;
            in_v_reg    <= item.velocity_in;
            in_pb_reg   <= item.personal_best;
            in_gb_reg   <= item.leader_pos;
            in_r1_reg   <= item.rand_cognitive;
            in_r2_reg   <= item.rand_social;
            in_c1_reg   <= item.cognitive_coeff;
            in_c2_reg   <= item.social_coeff;
            in_vmax_reg <= item.vel_max;
            in_vmin_reg <= item.vel_min;
            in_last_reg <= item.last_dim;
        end
    end

    // Stage 1: coefficient sum, inertia product, gain products, differences.
    logic [RHO_W-1:0]          s1_rho_reg;
    logic                      s1_big_reg;
    logic [COEF_W-1:0]         s1_rhom4_reg;
    logic signed [49:0]        s1_iv_reg;
    logic [34:0]               s1_kr1_reg, s1_kr2_reg;
    logic signed [POS_W:0]     s1_d1_reg, s1_d2_reg;
    logic signed [POS_W-1:0]   s1_x_reg, s1_vmax_reg, s1_vmin_reg;
    logic                      s1_last_reg;
    logic [RHO_W-1:0]          s1_rho_next;
    logic [RHO_W-1:0]          s1_rhom4_full;

    always_comb
    begin
        s1_rho_next   = {1'b0, in_c1_reg} + {1'b0, in_c2_reg};
        s1_rhom4_full = s1_rho_next - FX_FOUR;
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[1])
        begin
            s1_rho_reg   <= s1_rho_next;
            s1_big_reg   <= s1_rho_next > FX_FOUR;
            s1_rhom4_reg <= s1_rhom4_full[COEF_W-1:0];
            s1_iv_reg    <= $signed({1'b0, inertia_reg}) * in_v_reg;
            s1_kr1_reg   <= 35'(in_c1_reg) * 35'(in_r1_reg);
            s1_kr2_reg   <= 35'(in_c2_reg) * 35'(in_r2_reg);
            s1_d1_reg    <= {in_pb_reg[POS_W-1], in_pb_reg} - {in_x_reg[POS_W-1], in_x_reg};
            s1_d2_reg    <= {in_gb_reg[POS_W-1], in_gb_reg} - {in_x_reg[POS_W-1], in_x_reg};
            s1_x_reg     <= in_x_reg;
            s1_vmax_reg  <= in_vmax_reg;
            s1_vmin_reg  <= in_vmin_reg;
            s1_last_reg  <= in_last_reg;
        end
    end

    // Stage 2: radicand and the two attraction terms.
    logic [SQN_W-1:0]         s2_sqn_reg;
    logic [RHO_W-1:0]         s2_rho_reg;
    logic                     s2_big_reg;
    logic signed [49:0]       s2_iv_reg;
    logic signed [52:0]       s2_m1_reg, s2_m2_reg;
    logic signed [POS_W-1:0]  s2_x_reg, s2_vmax_reg, s2_vmin_reg;
    logic                     s2_last_reg;

    always_ff @(posedge clk)
    begin
        if (stg_en[2])
        begin
            s2_sqn_reg  <= s1_big_reg ? SQN_W'(s1_rho_reg) * SQN_W'(s1_rhom4_reg) : '0;
            s2_rho_reg  <= s1_rho_reg;
            s2_big_reg  <= s1_big_reg;
            s2_iv_reg   <= s1_iv_reg;
            s2_m1_reg   <= $signed({1'b0, s1_kr1_reg[34:16]}) * s1_d1_reg;
            s2_m2_reg   <= $signed({1'b0, s1_kr2_reg[34:16]}) * s1_d2_reg;
            s2_x_reg    <= s1_x_reg;
            s2_vmax_reg <= s1_vmax_reg;
            s2_vmin_reg <= s1_vmin_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Stage 3: velocity sum, floored to Q16.16; square root seeded.
    side_t              sd_reg     [3:ST_DVL];
    logic [SQN_W-1:0]   sq_n_reg   [3:ST_SQL];
    logic [SQR_W-1:0]   sq_rem_reg [3:ST_SQL];
    logic [ROOT_W-1:0]  sq_root_reg[3:ST_SQL];
    logic signed [54:0] s3_sum;

    always_comb
    begin
        s3_sum = 55'(s2_iv_reg) + 55'(s2_m1_reg) + 55'(s2_m2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[3])
        begin
            sd_reg[3].t    <= s3_sum[54:16];
            sd_reg[3].x    <= s2_x_reg;
            sd_reg[3].vmax <= s2_vmax_reg;
            sd_reg[3].vmin <= s2_vmin_reg;
            sd_reg[3].last <= s2_last_reg;
            sd_reg[3].big  <= s2_big_reg;
            sd_reg[3].rho  <= s2_rho_reg;
            sq_n_reg[3]    <= s2_sqn_reg;
            sq_rem_reg[3]  <= '0;
            sq_root_reg[3] <= '0;
        end
    end

    // Side data rides along the square root and divide stages.
    for (genvar s = ST_SQ0; s <= ST_DVL; s++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (stg_en[s])
            begin
                sd_reg[s] <= sd_reg[s - 1];
            end
        end
    end

    // Square root, one root bit per stage, most significant pair first.
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        localparam int S  = ST_SQ0 + k;
        localparam int BI = 2 * (SQ_STEPS - 1 - k);
        logic [SQR_W-1:0] rem_sh;
        logic [SQR_W-1:0] trial;
        logic             ge;

        always_comb
        begin
            rem_sh = {sq_rem_reg[S - 1][SQR_W-3:0], sq_n_reg[S - 1][BI + 1:BI]};
            trial  = {1'b0, sq_root_reg[S - 1], 2'b01};
            ge     = rem_sh >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (stg_en[S])
            begin
                sq_n_reg[S]    <= sq_n_reg[S - 1];
                sq_rem_reg[S]  <= ge ? rem_sh - trial : rem_sh;
                sq_root_reg[S] <= {sq_root_reg[S - 1][ROOT_W-2:0], ge};
            end
        end
    end

    // Divisor of the constriction factor.
    logic [DEN_W-1:0] dv_den_first;

    always_comb
    begin
        dv_den_first = DEN_W'(sd_reg[ST_SQL].rho) + DEN_W'(sq_root_reg[ST_SQL]) - FX_TWO;
    end

    // Restoring divide of 2.0 by the divisor, one quotient bit per stage.
    logic [DEN_W-1:0]  dv_den_reg [ST_DV0:ST_DVL];
    logic [DIVR_W-1:0] dv_rem_reg [ST_DV0:ST_DVL];
    logic [Q_W-1:0]    dv_q_reg   [ST_DV0:ST_DVL];

    for (genvar j = 0; j < DV_STEPS; j++)
    begin : g_div
        localparam int S = ST_DV0 + j;
        localparam int B = DV_STEPS - 1 - j;
        logic [DEN_W-1:0]  den;
        logic [DIVR_W-1:0] rem;
        logic [Q_W-1:0]    q;
        logic [DIVR_W-1:0] trial;
        logic [Q_W-1:0]    q_next;
        logic              ge;

        if (j == 0)
        begin : g_first
            assign den = dv_den_first;
            assign rem = DIV_NUM;
            assign q   = '0;
        end
        else
        begin : g_rest
            assign den = dv_den_reg[S - 1];
            assign rem = dv_rem_reg[S - 1];
            assign q   = dv_q_reg[S - 1];
        end

        always_comb
        begin
            trial     = DIVR_W'(den) << B;
            ge        = rem >= trial;
            q_next    = q;
            q_next[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (stg_en[S])
            begin
                dv_den_reg[S] <= den;
                dv_rem_reg[S] <= ge ? rem - trial : rem;
                dv_q_reg[S]   <= q_next;
            end
        end
    end

    // Constriction multiply, floored to Q16.16.
    logic signed [CHI_W-1:0]   mul_chi;
    logic signed [T_W+CHI_W-1:0] mul_prod;
    logic signed [U_W-1:0]     u_reg;
    logic signed [POS_W-1:0]   mu_x_reg, mu_vmax_reg, mu_vmin_reg;
    logic                      mu_last_reg;

    always_comb
    begin
        mul_chi  = sd_reg[ST_DVL].big ? -$signed({2'b00, dv_q_reg[ST_DVL]}) : FX_ONE;
        mul_prod = sd_reg[ST_DVL].t * mul_chi;
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[ST_MUL])
        begin
            u_reg       <= mul_prod[T_W+CHI_W-1:16];
            mu_x_reg    <= sd_reg[ST_DVL].x;
            mu_vmax_reg <= sd_reg[ST_DVL].vmax;
            mu_vmin_reg <= sd_reg[ST_DVL].vmin;
            mu_last_reg <= sd_reg[ST_DVL].last;
        end
    end

    // Velocity clamp and saturated position.
    logic signed [U_W-1:0]   cl_v;
    logic signed [POS_W-1:0] cl_nv;
    logic signed [POS_W:0]   cl_np;
    logic signed [POS_W-1:0] cl_np_sat;
    logic signed [POS_W-1:0] nv_reg, np_reg;
    logic                    last_reg;

    always_comb
    begin
        cl_v = u_reg;
        if (u_reg > U_W'(mu_vmax_reg))
        begin
            cl_v = U_W'(mu_vmax_reg);
        end
        if (u_reg < U_W'(mu_vmin_reg))
        begin
            cl_v = U_W'(mu_vmin_reg);
        end
        cl_nv = cl_v[POS_W-1:0];
        cl_np = {mu_x_reg[POS_W-1], mu_x_reg} + {cl_nv[POS_W-1], cl_nv};
        if (cl_np[POS_W] != cl_np[POS_W-1])
        begin
            cl_np_sat = cl_np[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        else
        begin
            cl_np_sat = cl_np[POS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[ST_OUT])
        begin
            nv_reg   <= cl_nv;
            np_reg   <= cl_np_sat;
            last_reg <= mu_last_reg;
        end
    end

    assign res.valid        = vl_reg[ST_OUT];
    assign res.new_velocity = nv_reg;
    assign res.new_position = np_reg;
    assign res.last_dim_out = last_reg;

    // The finished square root leaves its remainder consistent with the root.
    a_sqrt_exact: assert property (@(posedge clk) disable iff (!rst_n)
        vl_reg[ST_SQL] |->
            (SQN_W'(sq_root_reg[ST_SQL]) * SQN_W'(sq_root_reg[ST_SQL])
             + SQN_W'(sq_rem_reg[ST_SQL]) == sq_n_reg[ST_SQL])
            && (SQN_W'(sq_rem_reg[ST_SQL]) <= 2 * SQN_W'(sq_root_reg[ST_SQL])))
        else $error("square root remainder inconsistent");

    // The divider quotient and remainder reconstruct the numerator.
    a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (vl_reg[ST_DVL] && sd_reg[ST_DVL].big) |->
            (DIVR_W'(dv_q_reg[ST_DVL]) * DIVR_W'(dv_den_reg[ST_DVL])
             + dv_rem_reg[ST_DVL] == DIV_NUM)
            && (dv_rem_reg[ST_DVL] < DIVR_W'(dv_den_reg[ST_DVL])))
        else $error("divider result inconsistent");

    // A held multiply stage keeps its beat until the clamp stage takes it.
    a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vl_reg[ST_MUL] && !stg_en[ST_MUL]) |=> (vl_reg[ST_MUL] && $stable(u_reg)))
        else $error("multiply stage lost a held beat");

endmodule

/* verif/pso_velocity_update_tb.sv */
// ----------------------------------------------------------------------------
// PSO velocity update testbench
// Streams dimension beats through the velocity update pipeline. Each
// accepted beat is predicted in fixed point from the inertia weight, the
// constriction factor, the clamp and the position saturation. The result
// channel is checked beat by beat against the oldest prediction. Directed
// corner beats come first, then inertia weight sweeps, idle and stall
// phases, and a long receiver hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module pso_velocity_update_tb;
    import pso_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q_ONE    = 64'd65536;
    localparam longint Q_TWO    = 64'd131072;
    localparam longint Q_FOUR   = 64'd262144;
    localparam int     DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] velocity_in;
        logic signed [POS_W-1:0] personal_best;
        logic signed [POS_W-1:0] leader_pos;
        logic [RATE_W-1:0]       rand_cognitive;
        logic [RATE_W-1:0]       rand_social;
        logic [COEF_W-1:0]       cognitive_coeff;
        logic [COEF_W-1:0]       social_coeff;
        logic signed [POS_W-1:0] vel_max;
        logic signed [POS_W-1:0] vel_min;
        logic                    last_dim;
    } dim_beat_t;

    typedef struct {
        logic signed [POS_W-1:0] new_velocity;
        logic signed [POS_W-1:0] new_position;
        logic                    last_dim_out;
    } update_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [RATE_W-1:0] cfg_wdata;

    pso_item_if item_ch ();
    pso_res_if  res_ch ();

    pso_velocity_update uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch.sink),
        .res       (res_ch.source)
    );

    // Predictor state and scoreboard.
    logic [RATE_W-1:0] inertia_model;
    update_t           pending_updates[$];
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_left;
    int                error_count;
    int                beats_sent;
    int                beats_checked;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #5ms;
        $display("Timeout at %0t with %0d results outstanding", $time,
                 pending_updates.size());
        $display("pso_velocity_update_tb: FAIL");
        $finish;
    end

    // Integer square root, rounded down.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Constriction factor in Q16.16; negative above a coefficient sum of 4.
    function automatic longint constriction_factor(logic [COEF_W-1:0] c1,
                                                   logic [COEF_W-1:0] c2);
        longint unsigned rho;
        longint unsigned root;
        longint unsigned den;
        rho = longint'(c1) + longint'(c2);
        if (rho <= Q_FOUR)
            return Q_ONE;
        root = int_sqrt(rho * (rho - Q_FOUR));
        den = rho + root - Q_TWO;
        return -longint'((longint'(Q_TWO) << 16) / den);
    endfunction

    // Velocity and position update of one dimension.
    function automatic update_t compute_update(dim_beat_t d);
        update_t o;
        longint x, v, pb, gb, vmax, vmin, chi, k1, k2, sum, t, u, nv, np;
        x = d.position;
        v = d.velocity_in;
        pb = d.personal_best;
        gb = d.leader_pos;
        vmax = d.vel_max;
        vmin = d.vel_min;
        chi = constriction_factor(d.cognitive_coeff, d.social_coeff);
        k1 = (longint'(d.cognitive_coeff) * longint'(d.rand_cognitive)) >>> 16;
        k2 = (longint'(d.social_coeff) * longint'(d.rand_social)) >>> 16;
        sum = longint'(inertia_model) * v + k1 * (pb - x) + k2 * (gb - x);
        t = sum >>> 16;
        u = (t * chi) >>> 16;
        nv = u;
        if (u > vmax)
            nv = vmax;
        if (u < vmin)
            nv = vmin;
        np = x + nv;
        if (np > 64'sd2147483647)
            np = 64'sd2147483647;
        if (np < -64'sd2147483648)
            np = -64'sd2147483648;
        o.new_velocity = nv[31:0];
        o.new_position = np[31:0];
        o.last_dim_out = d.last_dim;
        return o;
    endfunction

    // Offer one beat, with a random idle gap in front, until it is accepted.
    task automatic send_dim(dim_beat_t d);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.position        = d.position;
        item_ch.velocity_in     = d.velocity_in;
        item_ch.personal_best   = d.personal_best;
        item_ch.leader_pos      = d.leader_pos;
        item_ch.rand_cognitive  = d.rand_cognitive;
        item_ch.rand_social     = d.rand_social;
        item_ch.cognitive_coeff = d.cognitive_coeff;
        item_ch.social_coeff    = d.social_coeff;
        item_ch.vel_max         = d.vel_max;
        item_ch.vel_min         = d.vel_min;
        item_ch.last_dim        = d.last_dim;
        item_ch.valid           = 1'b1;
        do
            @(posedge clk);
        while (!item_ch.ready);
        pending_updates.push_back(compute_update(d));
        beats_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        item_ch.valid = 1'b0;
    endtask

    // Wait until every result is back and the pipeline has emptied.
    task automatic wait_drain();
        stop_sending();
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_inertia(logic [RATE_W-1:0] w);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = w;
        @(negedge clk);
        cfg_we = 1'b0;
        inertia_model = w;
    endtask

    function automatic logic [COEF_W-1:0] pick_coeff();
        if ($urandom_range(0, 9) == 0)
            return COEF_W'($urandom);
        return COEF_W'($urandom_range(98304, 163840));
    endfunction

    // Mostly plausible swarm dimensions, some fully random bit patterns.
    function automatic dim_beat_t random_dim();
        dim_beat_t d;
        logic signed [POS_W-1:0] a, b;
        if ($urandom_range(0, 9) < 7)
        begin
            d.position      = $signed($urandom_range(0, 2 << 20)) - (1 << 20);
            d.velocity_in   = $signed($urandom_range(0, 2 << 18)) - (1 << 18);
            d.personal_best = d.position + $signed($urandom_range(0, 1 << 19))
                              - (1 << 18);
            d.leader_pos    = d.position + $signed($urandom_range(0, 1 << 20))
                              - (1 << 19);
            a = $urandom_range(0, 1 << 19);
            d.vel_max = a;
            d.vel_min = -a;
        end
        else
        begin
            d.position      = $urandom;
            d.velocity_in   = $urandom;
            d.personal_best = $urandom;
            d.leader_pos    = $urandom;
            a = $urandom;
            b = $urandom;
            d.vel_max = ($urandom_range(0, 3) == 0 || a >= b) ? a : b;
            d.vel_min = ($urandom_range(0, 3) == 0 || a >= b) ? b : a;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            d.rand_cognitive = RATE_W'($urandom);
            d.rand_social    = RATE_W'($urandom);
        end
        else
        begin
            d.rand_cognitive = RATE_W'($urandom_range(0, 65536));
            d.rand_social    = RATE_W'($urandom_range(0, 65536));
        end
        d.cognitive_coeff = pick_coeff();
        d.social_coeff    = pick_coeff();
        d.last_dim        = 1'($urandom_range(0, 1));
        return d;
    endfunction

    task automatic send_random(int n);
        repeat (n) send_dim(random_dim());
    endtask

    // Receiver: random stalls, or a forced hold-off while hold_left runs.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
                res_ch.ready = 1'b0;
            else
                res_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Hold-off countdown.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_updates.size() == 0)
            begin
                $display("%0t: result beat with no prediction: vel %h pos %h last %b",
                         $time, res_ch.new_velocity, res_ch.new_position,
                         res_ch.last_dim_out);
                error_count++;
            end
            else
            begin
                update_t e;
                e = pending_updates.pop_front();
                beats_checked++;
                if (res_ch.new_velocity !== e.new_velocity)
                begin
                    $display("%0t: new_velocity expected %h actual %h", $time,
                             e.new_velocity, res_ch.new_velocity);
                    error_count++;
                end
                if (res_ch.new_position !== e.new_position)
                begin
                    $display("%0t: new_position expected %h actual %h", $time,
                             e.new_position, res_ch.new_position);
                    error_count++;
                end
                if (res_ch.last_dim_out !== e.last_dim_out)
                begin
                    $display("%0t: last_dim_out expected %b actual %b", $time,
                             e.last_dim_out, res_ch.last_dim_out);
                    error_count++;
                end
            end
        end
    end

    // Corner beats: field extremes, constriction on and off, clamps,
    // crossed limits and position saturation.
    task automatic test_directed();
        dim_beat_t d;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        d = '{position: 0, velocity_in: 0, personal_best: 0, leader_pos: 0,
              rand_cognitive: 0, rand_social: 0, cognitive_coeff: 98304,
              social_coeff: 98304, vel_max: 32'sh7FFFFFFF,
              vel_min: 32'sh80000000, last_dim: 1'b0};
        send_dim(d);
        // Coefficient sum exactly 4: no constriction.
        d.velocity_in = 32'sh00010000;
        d.personal_best = 32'sh00030000;
        d.leader_pos = -32'sh00020000;
        d.rand_cognitive = 65536;
        d.rand_social = 65536;
        d.cognitive_coeff = 131072;
        d.social_coeff = 131072;
        d.last_dim = 1'b1;
        send_dim(d);
        // Just above 4: negative constriction factor.
        d.social_coeff = 131073;
        send_dim(d);
        // Largest in-range and fully out-of-range coefficients.
        d.cognitive_coeff = 163840;
        d.social_coeff = 163840;
        send_dim(d);
        d.cognitive_coeff = 18'h3FFFF;
        d.social_coeff = 18'h3FFFF;
        d.rand_cognitive = 17'h1FFFF;
        d.rand_social = 17'h1FFFF;
        send_dim(d);
        d.cognitive_coeff = 0;
        d.social_coeff = 18'h3FFFF;
        send_dim(d);
        // Extreme operands with wide limits.
        d.position = 32'sh80000000;
        d.velocity_in = 32'sh7FFFFFFF;
        d.personal_best = 32'sh7FFFFFFF;
        d.leader_pos = 32'sh7FFFFFFF;
        d.cognitive_coeff = 163840;
        d.social_coeff = 98304;
        send_dim(d);
        d.position = 32'sh7FFFFFFF;
        d.velocity_in = 32'sh80000000;
        d.personal_best = 32'sh80000000;
        d.leader_pos = 32'sh80000000;
        send_dim(d);
        // Position saturation upward and downward.
        d.position = 32'sh7FFF0000;
        d.personal_best = 32'sh7FFFFFFF;
        d.leader_pos = 32'sh7FFFFFFF;
        d.velocity_in = 32'sh00100000;
        d.cognitive_coeff = 98304;
        d.vel_max = 32'sh7FFFFFFF;
        d.vel_min = 32'sh80000000;
        send_dim(d);
        d.position = 32'sh80010000;
        d.personal_best = 32'sh80000000;
        d.leader_pos = 32'sh80000000;
        d.velocity_in = -32'sh00100000;
        send_dim(d);
        // Clamp to the upper limit, to the lower limit, and crossed limits.
        d.position = 0;
        d.velocity_in = 32'sh00050000;
        d.personal_best = 32'sh00080000;
        d.leader_pos = 32'sh00080000;
        d.vel_max = 32'sh00010000;
        d.vel_min = -32'sh00010000;
        send_dim(d);
        d.velocity_in = -32'sh00050000;
        d.personal_best = -32'sh00080000;
        d.leader_pos = -32'sh00080000;
        send_dim(d);
        d.vel_max = -32'sh00010000;
        d.vel_min = 32'sh00010000;
        send_dim(d);
        d.velocity_in = 0;
        d.personal_best = 0;
        d.leader_pos = 0;
        send_dim(d);
        d.vel_max = 0;
        d.vel_min = 0;
        d.last_dim = 1'b0;
        send_dim(d);
        wait_drain();
    endtask

    // Inertia weight sweep, extremes included.
    task automatic test_inertia_sweep();
        logic [RATE_W-1:0] weights[5];
        weights = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768, INERTIA_RESET};
        send_idle_pct = 10;
        recv_stall_pct = 10;
        foreach (weights[i])
        begin
            write_inertia(weights[i]);
            send_random(45);
            wait_drain();
        end
    endtask

    // Random beats under each idle pattern.
    task automatic test_idle_phases();
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 48, 0, 6};
        recv_pct = '{0, 0, 48, 6};
        write_inertia(RATE_W'($urandom_range(0, 65536)));
        foreach (send_pct[i])
        begin
            send_idle_pct = send_pct[i];
            recv_stall_pct = recv_pct[i];
            send_random(150);
        end
        wait_drain();
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        hold_left = 200;
        send_random(120);
        wait_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.position = '0;
        item_ch.velocity_in = '0;
        item_ch.personal_best = '0;
        item_ch.leader_pos = '0;
        item_ch.rand_cognitive = '0;
        item_ch.rand_social = '0;
        item_ch.cognitive_coeff = '0;
        item_ch.social_coeff = '0;
        item_ch.vel_max = '0;
        item_ch.vel_min = '0;
        item_ch.last_dim = 1'b0;
        inertia_model = INERTIA_RESET;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        error_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_inertia_sweep();
        test_idle_phases();
        test_backpressure();

        $display("Sent %0d dimension beats, checked %0d results, %0d mismatches",
                 beats_sent, beats_checked, error_count);
        $display("Covered corner operands, five inertia weights, idle and stall mixes, ",
                 "and a full-pipeline hold-off");
        if (error_count == 0)
            $display("pso_velocity_update_tb: PASS");
        else
            $display("pso_velocity_update_tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/pso_pkg.sv
rtl/pso_item_if.sv
rtl/pso_res_if.sv
rtl/pso_velocity_update.sv
verif/pso_velocity_update_tb.sv
